>>> src/rnf_pkg.sv
// shared constants, payload types and the digit-to-character helper
package rnf_pkg;

    localparam int INT_BITS    = 31;
    localparam int FRAC_BITS   = 32;
    localparam int CFG_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CHAR_W      = 7;
    localparam int DIGIT_W     = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam int STACK_AW  = $clog2(INT_BITS);
    localparam int DCNT_W    = $clog2(INT_BITS + 1);
    localparam int BIT_CNT_W = $clog2(INT_BITS);

    localparam logic [CFG_IDX_W-1:0] REG_RADIX       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAC_DIGITS = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] RADIX_RESET       = CFG_W'(10);
    localparam logic [CFG_W-1:0] FRAC_DIGITS_RESET = CFG_W'(8);
    localparam logic [CFG_W-1:0] RADIX_MIN         = CFG_W'(2);
    localparam logic [CFG_W-1:0] RADIX_MAX         = CFG_W'(16);
    localparam logic [CFG_W-1:0] FRAC_DIGITS_MIN   = CFG_W'(1);
    localparam logic [CFG_W-1:0] FRAC_DIGITS_MAX   = CFG_W'(24);

    localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_COMMA   = 7'h2C;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;

    localparam logic [DIGIT_W-1:0] DEC_DIGIT_MAX = DIGIT_W'(9);
    localparam logic [DIGIT_W-1:0] HEX_OFFSET    = DIGIT_W'(10);

    typedef struct packed {
        logic                 negative;
        logic [INT_BITS-1:0]  integer_magnitude;
        logic [FRAC_BITS-1:0] fraction;
    } num_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } chr_t;

    typedef struct packed {
        logic                 negative;
        logic [INT_BITS-1:0]  integer_magnitude;
        logic [FRAC_BITS-1:0] fraction;
        logic [CFG_W-1:0]     radix;
        logic [CFG_W-1:0]     frac_limit;
        logic                 int_zero;
        logic                 frac_zero;
    } job_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d <= DEC_DIGIT_MAX)
        begin
            c = CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
        end
        else
        begin
            c = CH_UPPER_A + {{(CHAR_W-DIGIT_W){1'b0}}, DIGIT_W'(d - HEX_OFFSET)};
        end
        return c;
    endfunction

endpackage

>>> src/rnf_front.sv
// front end: configuration registers, input acceptance and job classification
module rnf_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rnf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rnf_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           num_valid,
    output logic                           num_ready,
    input  rnf_pkg::num_t                  num,
    output logic                           push,
    output rnf_pkg::job_t                  job,
    input  logic                           full
);
    import rnf_pkg::*;

    logic [CFG_W-1:0] radix_reg;
    logic [CFG_W-1:0] frac_digits_reg;
    logic [CFG_W-1:0] radix_clamped;
    logic [CFG_W-1:0] limit_clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg       <= RADIX_RESET;
            frac_digits_reg <= FRAC_DIGITS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIX:       radix_reg       <= cfg_data;
                REG_FRAC_DIGITS: frac_digits_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (radix_reg < RADIX_MIN)
            radix_clamped = RADIX_MIN;
        else if (radix_reg > RADIX_MAX)
            radix_clamped = RADIX_MAX;
        else
            radix_clamped = radix_reg;

        if (frac_digits_reg < FRAC_DIGITS_MIN)
            limit_clamped = FRAC_DIGITS_MIN;
        else if (frac_digits_reg > FRAC_DIGITS_MAX)
            limit_clamped = FRAC_DIGITS_MAX;
        else
            limit_clamped = frac_digits_reg;
    end

    assign num_ready = !full;
    assign push      = num_valid && !full;

    always_comb
    begin
        job.negative          = num.negative;
        job.integer_magnitude = num.integer_magnitude;
        job.fraction          = num.fraction;
        job.radix             = radix_clamped;
        job.frac_limit        = limit_clamped;
        job.int_zero          = (num.integer_magnitude == '0);
        job.frac_zero         = (num.fraction == '0);
    end

endmodule

>>> src/rnf_queue.sv
// short job queue between front and back
module rnf_queue #(
    parameter int DEPTH = rnf_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rnf_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output rnf_pkg::job_t pop_data,
    output logic          empty
);
    import rnf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> src/rnf_back.sv
// back end: bit-serial radix divider, digit stack, fraction multiplier, character output
module rnf_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          empty,
    input  rnf_pkg::job_t job,
    output logic          pop,
    output logic          chr_valid,
    input  logic          chr_ready,
    output rnf_pkg::chr_t chr
);
    import rnf_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SIGN   = 3'd1;
    localparam logic [2:0] S_DIVCHK = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_INT    = 3'd4;
    localparam logic [2:0] S_COMMA  = 3'd5;
    localparam logic [2:0] S_FRAC   = 3'd6;

    localparam int PROD_W = FRAC_BITS + CFG_W;

    logic [2:0]           state_reg,     state_next;
    logic                 neg_reg,       neg_next;
    logic                 int_zero_reg,  int_zero_next;
    logic                 frac_zero_reg, frac_zero_next;
    logic [INT_BITS-1:0]  quo_reg,       quo_next;
    logic [DIGIT_W-1:0]   rem_reg,       rem_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg,   bit_cnt_next;
    logic [DCNT_W-1:0]    dcnt_reg,      dcnt_next;
    logic [FRAC_BITS-1:0] frac_reg,      frac_next;
    logic [CFG_W-1:0]     fcnt_reg,      fcnt_next;
    logic [CFG_W-1:0]     radix_reg,     radix_next;
    logic [CFG_W-1:0]     lim_reg,       lim_next;
    logic                 out_valid_reg, out_valid_next;
    chr_t                 out_data_reg,  out_data_next;

    logic [DIGIT_W-1:0]   digit_stack [INT_BITS];
    logic                 stack_we;
    logic [STACK_AW-1:0]  stack_rd_idx;
    logic [DIGIT_W-1:0]   stack_rd;

    logic                 out_free;
    logic                 emit;
    logic [CHAR_W-1:0]    emit_char;
    logic                 emit_last;

    logic [DIGIT_W:0]     div_trial;
    logic                 div_ge;
    logic [DIGIT_W-1:0]   rem_step;
    logic [PROD_W-1:0]    prod;
    logic [FRAC_BITS-1:0] prod_frac;
    logic [CFG_W-1:0]     fcnt_inc;

    assign out_free     = !out_valid_reg || chr_ready;
    assign stack_rd_idx = STACK_AW'(dcnt_reg - 1'b1);
    assign stack_rd     = digit_stack[stack_rd_idx];

    // one quotient bit per cycle, remainder stays below the radix
    assign div_trial = {rem_reg, quo_reg[INT_BITS-1]};
    assign div_ge    = (div_trial >= radix_reg);
    assign rem_step  = div_ge ? DIGIT_W'(div_trial - radix_reg)
                              : div_trial[DIGIT_W-1:0];

    assign prod      = {{CFG_W{1'b0}}, frac_reg} * {{FRAC_BITS{1'b0}}, radix_reg};
    assign prod_frac = prod[FRAC_BITS-1:0];
    assign fcnt_inc  = fcnt_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        int_zero_next  = int_zero_reg;
        frac_zero_next = frac_zero_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        bit_cnt_next   = bit_cnt_reg;
        dcnt_next      = dcnt_reg;
        frac_next      = frac_reg;
        fcnt_next      = fcnt_reg;
        radix_next     = radix_reg;
        lim_next       = lim_reg;
        pop            = 1'b0;
        stack_we       = 1'b0;
        emit           = 1'b0;
        emit_char      = CH_ZERO;
        emit_last      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop            = 1'b1;
                    neg_next       = job.negative;
                    int_zero_next  = job.int_zero;
                    frac_zero_next = job.frac_zero;
                    quo_next       = job.integer_magnitude;
                    frac_next      = job.fraction;
                    radix_next     = job.radix;
                    lim_next       = job.frac_limit;
                    dcnt_next      = '0;
                    state_next     = S_SIGN;
                end
            end
            S_SIGN:
            begin
                if (!neg_reg)
                begin
                    state_next = S_DIVCHK;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    emit_char  = CH_MINUS;
                    state_next = S_DIVCHK;
                end
            end
            S_DIVCHK:
            begin
                if (quo_reg == '0 || dcnt_reg == DCNT_W'(INT_BITS))
                begin
                    state_next = S_INT;
                end
                else
                begin
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                quo_next = {quo_reg[INT_BITS-2:0], div_ge};
                rem_next = rem_step;
                if (bit_cnt_reg == BIT_CNT_W'(INT_BITS - 1))
                begin
                    stack_we   = 1'b1;
                    dcnt_next  = dcnt_reg + 1'b1;
                    state_next = S_DIVCHK;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                end
            end
            S_INT:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (int_zero_reg)
                    begin
                        emit_char  = CH_ZERO;
                        state_next = S_COMMA;
                    end
                    else
                    begin
                        emit_char = digit_char(stack_rd);
                        dcnt_next = dcnt_reg - 1'b1;
                        if (dcnt_reg == DCNT_W'(1))
                            state_next = S_COMMA;
                    end
                end
            end
            S_COMMA:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_char  = CH_COMMA;
                    fcnt_next  = '0;
                    state_next = S_FRAC;
                end
            end
            S_FRAC:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (frac_zero_reg)
                    begin
                        emit_char  = CH_ZERO;
                        emit_last  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_char = digit_char(prod[FRAC_BITS +: DIGIT_W]);
                        emit_last = (prod_frac == '0) || (fcnt_inc >= lim_reg);
                        frac_next = prod_frac;
                        fcnt_next = fcnt_inc;
                        if (emit_last)
                            state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next          = 1'b1;
            out_data_next.char_code = emit_char;
            out_data_next.last      = emit_last;
        end
        else if (chr_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            quo_reg       <= '0;
            frac_reg      <= '0;
            dcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            quo_reg       <= quo_next;
            frac_reg      <= frac_next;
            dcnt_reg      <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg       <= neg_next;
        int_zero_reg  <= int_zero_next;
        frac_zero_reg <= frac_zero_next;
        rem_reg       <= rem_next;
        bit_cnt_reg   <= bit_cnt_next;
        fcnt_reg      <= fcnt_next;
        radix_reg     <= radix_next;
        lim_reg       <= lim_next;
        out_data_reg  <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
            digit_stack[dcnt_reg[STACK_AW-1:0]] <= rem_step;
    end

    assign chr_valid = out_valid_reg;
    assign chr       = out_data_reg;

endmodule

>>> src/radix_number_formatter.sv
// top level of the radix number formatter: front end, job queue and back end
//
//   channel   direction   handshake               payload
//   num       in          num_valid / num_ready   rnf_pkg::num_t (sign, integer, Q0.32 fraction)
//   chr       out         chr_valid / chr_ready   rnf_pkg::chr_t (ascii char, last flag)
//   cfg       in          cfg_we                  cfg_index, cfg_data (radix, frac_digits)
//
// each integer digit comes from the bit-serial divider, S_DIVCHK and then S_DIV at
// one quotient bit per cycle; output characters then follow at one per cycle
// while chr_ready keeps the output register free
// reset is asynchronous active low; config and queue come up ready at once
// the queue takes new items while the back end works or waits on chr_ready
module radix_number_formatter #(
    parameter int QUEUE_DEPTH = rnf_pkg::QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rnf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rnf_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           num_valid,
    output logic                           num_ready,
    input  rnf_pkg::num_t                  num,
    output logic                           chr_valid,
    input  logic                           chr_ready,
    output rnf_pkg::chr_t                  chr
);
    import rnf_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic empty;
    job_t push_job;
    job_t pop_job;

    rnf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .num_valid (num_valid),
        .num_ready (num_ready),
        .num       (num),
        .push      (push),
        .job       (push_job),
        .full      (full)
    );

    rnf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_job),
        .empty     (empty)
    );

    rnf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .job       (pop_job),
        .pop       (pop),
        .chr_valid (chr_valid),
        .chr_ready (chr_ready),
        .chr       (chr)
    );

endmodule
